@@ design/clbrg_pkg.sv @@
// Shared types, codes and CRC-32 tables for the crash loop boot record guard.
// No dependencies; every other design file imports this package.
package clbrg_pkg;

	localparam int unsigned CRC_BITS  = 96;
	localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
	localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
	localparam logic [7:0]  COUNT_MAX = 8'hFF;

	typedef enum logic [2:0] {
		CMD_NOTE_BOOT = 3'd0,
		CMD_MARK      = 3'd1,
		CMD_ACK       = 3'd2,
		CMD_CLEAR     = 3'd3,
		CMD_CHECK     = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_SCHEMA_ID       = 2'd0,
		CFG_FAILURE_LIMIT   = 2'd1,
		CFG_SUBSYSTEM_COUNT = 2'd2
	} cfg_addr_t;

	typedef struct packed {
		logic [2:0]  command;
		logic        boot_after_crash;
		logic [7:0]  subsystem;
		logic [31:0] rec_schema;
		logic [31:0] rec_generation;
		logic [7:0]  rec_crash_count;
		logic [7:0]  rec_last_active;
		logic [7:0]  rec_reserved_a;
		logic [7:0]  rec_reserved_b;
		logic [31:0] rec_checksum;
	} req_t;

	typedef struct packed {
		logic [31:0] new_schema;
		logic [31:0] new_generation;
		logic [7:0]  new_crash_count;
		logic [7:0]  new_last_active;
		logic [31:0] new_checksum;
		logic        record_changed;
		logic        record_was_valid;
		logic [7:0]  previous_active;
		logic        crash_blamed;
		logic        crash_loop;
		logic        accepted;
	} rsp_t;

	// Decision stage result, before the new record is sealed.
	typedef struct packed {
		logic [31:0] schema;
		logic [31:0] generation;
		logic [7:0]  crash_count;
		logic [7:0]  last_active;
		logic [31:0] old_checksum;
		logic        changed;
		logic        was_valid;
		logic [7:0]  previous_active;
		logic        attributed;
		logic        loop;
		logic        accepted;
	} mid_t;

	typedef struct packed {
		logic [31:0] schema_id;
		logic [7:0]  failure_limit;
		logic [7:0]  subsystem_count;
	} cfg_regs_t;

	typedef logic [CRC_BITS-1:0][31:0] crc_tab_t;

	// Bitwise reflected CRC over twelve bytes, byte 0 in the low bits.
	// Used only to build the constant tables below.
	function automatic logic [31:0] crc_raw(logic [31:0] init, logic [CRC_BITS-1:0] d);
		logic [31:0] c;
		c = init;
		for (int k = 0; k < CRC_BITS / 8; k++) begin
			c = c ^ {24'd0, d[8*k +: 8]};
			for (int b = 0; b < 8; b++) begin
				c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
			end
		end
		return c;
	endfunction

	function automatic crc_tab_t crc_cols();
		crc_tab_t t;
		for (int i = 0; i < CRC_BITS; i++) begin
			t[i] = crc_raw(32'd0, CRC_BITS'(1) << i);
		end
		return t;
	endfunction

	// CRC is affine in the data: seal = CRC_ZERO ^ XOR of columns of set bits.
	localparam crc_tab_t    CRC_COL  = crc_cols();
	localparam logic [31:0] CRC_ZERO = crc_raw(ALL_ONES, '0) ^ ALL_ONES;

endpackage

@@ design/clbrg_if.sv @@
// Valid/ready channel interfaces for requests, results and register writes.
// Depends on clbrg_pkg for the payload types.
interface clbrg_req_if import clbrg_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface clbrg_rsp_if import clbrg_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface clbrg_cfg_if import clbrg_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [1:0]  addr;
	logic [31:0] data;
	modport source (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface

@@ design/crash_loop_boot_record_guard.sv @@
// Top level of the crash loop boot record guard: channels, pipeline and registers.
// Depends on clbrg_pkg, clbrg_if, clbrg_crc and clbrg_decide.
//
// Usage
//   req : one request per handshake - a command, the crash-like reset flag, a
//         subsystem code and the stored sixteen-byte boot record.
//   rsp : one result per request - the record after the command, resealed with
//         a fresh CRC-32 when rewritten, plus the validity and crash decision.
//   cfg : register writes (schema id, failure limit, subsystem count); always
//         ready, to be used only while no request is in flight.
// Throughput is one request per cycle: the input register, the decision
// stage and the result register each advance as soon as the stage after
// them is empty or moving on, so the block keeps taking requests while a
// finished result waits on rsp.
// The depth of the path is set by the validation CRC network and the
// generation increment in the decision stage, and by the seal CRC in the last.
// When the receiver stalls, hold the result; the stages behind fill up and
// req.ready falls once all three are occupied.
// Reset empties every stage and loads the registers with schema id 1,
// failure limit 3 and subsystem count 2.
module crash_loop_boot_record_guard import clbrg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	clbrg_req_if.sink   req,
	clbrg_rsp_if.source rsp,
	clbrg_cfg_if.sink   cfg
);

	cfg_regs_t   regs_q;
	logic        valid_s1, valid_s2, valid_s3;
	req_t        req_s1;
	mid_t        mid_comb, mid_s2;
	rsp_t        rsp_s3;
	logic [31:0] seal;
	logic        adv1, adv2, adv3;

	// Configuration registers; writes are never refused
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.schema_id       <= 32'd1;
			regs_q.failure_limit   <= 8'd3;
			regs_q.subsystem_count <= 8'd2;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				CFG_SCHEMA_ID:       regs_q.schema_id       <= cfg.data;
				CFG_FAILURE_LIMIT:   regs_q.failure_limit   <= cfg.data[7:0];
				CFG_SUBSYSTEM_COUNT: regs_q.subsystem_count <= cfg.data[7:0];
				default: begin
					// unmapped address: drop the write
				end
			endcase
		end
	end

	// Stage advance: a stage moves when it is empty or its successor moves
	assign adv3      = !valid_s3 || rsp.ready;
	assign adv2      = !valid_s2 || adv3;
	assign adv1      = !valid_s1 || adv2;
	assign req.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= req.valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (adv1 && req.valid) begin
			req_s1 <= req.data;
		end
	end

	// Validate the record and apply the command
	clbrg_decide u_decide (
		.req (req_s1),
		.regs(regs_q),
		.mid (mid_comb)
	);

	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			mid_s2 <= mid_comb;
		end
	end

	// Seal the new record; reserved bytes are always zero after a rewrite
	clbrg_crc u_seal (
		.data({16'd0, mid_s2.last_active, mid_s2.crash_count,
		       mid_s2.generation, mid_s2.schema}),
		.crc (seal)
	);

	always_ff @(posedge clk) begin
		if (adv3 && valid_s2) begin
			rsp_s3.new_schema       <= mid_s2.schema;
			rsp_s3.new_generation   <= mid_s2.generation;
			rsp_s3.new_crash_count  <= mid_s2.crash_count;
			rsp_s3.new_last_active  <= mid_s2.last_active;
			rsp_s3.new_checksum     <= mid_s2.changed ? seal : mid_s2.old_checksum;
			rsp_s3.record_changed   <= mid_s2.changed;
			rsp_s3.record_was_valid <= mid_s2.was_valid;
			rsp_s3.previous_active  <= mid_s2.previous_active;
			rsp_s3.crash_blamed     <= mid_s2.attributed;
			rsp_s3.crash_loop       <= mid_s2.loop;
			rsp_s3.accepted         <= mid_s2.accepted;
		end
	end

	assign rsp.valid = valid_s3;
	assign rsp.data  = rsp_s3;

endmodule

@@ design/clbrg_crc.sv @@
// Parallel CRC-32 network over the twelve sealed record bytes.
// Depends on clbrg_pkg for the column table.
module clbrg_crc import clbrg_pkg::*; (
	input  logic [CRC_BITS-1:0] data,
	output logic [31:0]         crc
);

	always_comb begin
		crc = CRC_ZERO;
		for (int i = 0; i < CRC_BITS; i++) begin
			if (data[i]) begin
				crc = crc ^ CRC_COL[i];
			end
		end
	end

endmodule

@@ design/clbrg_decide.sv @@
// Record validation and command decision: builds the new record before sealing.
// Depends on clbrg_pkg and clbrg_crc.
module clbrg_decide import clbrg_pkg::*; (
	input  req_t      req,
	input  cfg_regs_t regs,
	output mid_t      mid
);

	logic [31:0] crc_in;
	logic        valid;
	logic        sub_ok;
	logic [31:0] base_schema;
	logic [31:0] base_gen;
	logic [7:0]  base_count;
	logic [7:0]  base_last;
	logic [31:0] next_gen;
	logic        attr;
	logic [7:0]  boot_count;

	clbrg_crc u_check (
		.data({req.rec_reserved_b, req.rec_reserved_a, req.rec_last_active,
		       req.rec_crash_count, req.rec_generation, req.rec_schema}),
		.crc (crc_in)
	);

	always_comb begin
		valid = (req.rec_schema == regs.schema_id) && (req.rec_generation != '0) &&
		        (req.rec_last_active < regs.subsystem_count) &&
		        (req.rec_reserved_a == '0) && (req.rec_reserved_b == '0) &&
		        (req.rec_checksum == crc_in);
		sub_ok = (req.subsystem != '0) && (req.subsystem < regs.subsystem_count);

		// reinitialise an invalid record
		base_schema = valid ? req.rec_schema      : regs.schema_id;
		base_gen    = valid ? req.rec_generation  : 32'd1;
		base_count  = valid ? req.rec_crash_count : 8'd0;
		base_last   = valid ? req.rec_last_active : 8'd0;
		next_gen    = (base_gen == ALL_ONES) ? 32'd1 : base_gen + 32'd1;

		attr       = req.boot_after_crash && (base_last != '0);
		boot_count = attr ? ((base_count == COUNT_MAX) ? COUNT_MAX : base_count + 8'd1)
		                  : 8'd0;

		// default: record passes through unchanged
		mid.schema          = req.rec_schema;
		mid.generation      = req.rec_generation;
		mid.crash_count     = req.rec_crash_count;
		mid.last_active     = req.rec_last_active;
		mid.old_checksum    = req.rec_checksum;
		mid.changed         = 1'b0;
		mid.was_valid       = valid;
		mid.previous_active = '0;
		mid.attributed      = 1'b0;
		mid.loop            = 1'b0;
		mid.accepted        = 1'b1;

		unique case (req.command)
			CMD_NOTE_BOOT: begin
				mid.schema          = base_schema;
				mid.generation      = next_gen;
				mid.crash_count     = boot_count;
				mid.last_active     = '0;
				mid.changed         = 1'b1;
				mid.previous_active = base_last;
				mid.attributed      = attr;
				mid.loop            = attr && (boot_count >= regs.failure_limit);
			end
			CMD_MARK: begin
				if (sub_ok) begin
					mid.schema      = base_schema;
					mid.generation  = next_gen;
					mid.crash_count = base_count;
					mid.last_active = req.subsystem;
					mid.changed     = 1'b1;
				end else begin
					mid.accepted = 1'b0;
				end
			end
			CMD_ACK: begin
				if (valid && sub_ok && (req.rec_last_active == req.subsystem) &&
				    (req.rec_crash_count != '0)) begin
					mid.generation  = next_gen;
					mid.crash_count = '0;
					mid.changed     = 1'b1;
				end else begin
					mid.accepted = 1'b0;
				end
			end
			CMD_CLEAR: begin
				mid.schema      = base_schema;
				mid.generation  = next_gen;
				mid.crash_count = '0;
				mid.last_active = '0;
				mid.changed     = 1'b1;
			end
			default: begin
				// check and unused codes: leave the record as it is
			end
		endcase
	end

endmodule

@@ tb/clbrg_outcome_checker.sv @@
`timescale 1ns / 1ps
// Outcome checker for the crash loop boot record guard: follows register writes,
// predicts each request's resealed record and decision, and compares results.
// Depends on clbrg_pkg and the channel interfaces of clbrg_if.
module clbrg_outcome_checker import clbrg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	clbrg_req_if req,
	clbrg_rsp_if rsp,
	clbrg_cfg_if cfg,
	output int   errors,
	output int   pending
);

	localparam logic [31:0] REFLECTED_POLY = 32'hEDB88320;

	logic [31:0] schema_id;
	logic [7:0]  failure_limit;
	logic [7:0]  subsystem_count;
	rsp_t        awaited_outcomes[$];

	// Bit-serial reflected CRC-32 over the twelve sealed bytes, byte 0 first.
	function automatic logic [31:0] record_seal(logic [31:0] schema, logic [31:0] generation,
			logic [7:0] crash_count, logic [7:0] last_active, logic [7:0] res_a,
			logic [7:0] res_b);
		logic [95:0] stream;
		logic [31:0] c;
		stream = {res_b, res_a, last_active, crash_count, generation, schema};
		c = '1;
		for (int i = 0; i < 96; i++) begin
			c = c ^ {31'd0, stream[i]};
			c = c[0] ? ((c >> 1) ^ REFLECTED_POLY) : (c >> 1);
		end
		return ~c;
	endfunction

	function automatic rsp_t guard_outcome(req_t q);
		rsp_t        o;
		logic        intact;
		logic        sub_ok;
		logic        rewrite;
		logic [31:0] schema;
		logic [31:0] generation;
		logic [7:0]  crash_count;
		logic [7:0]  last_active;
		schema      = q.rec_schema;
		generation  = q.rec_generation;
		crash_count = q.rec_crash_count;
		last_active = q.rec_last_active;
		intact = schema == schema_id && generation != '0 && last_active < subsystem_count &&
			q.rec_reserved_a == '0 && q.rec_reserved_b == '0 &&
			q.rec_checksum == record_seal(schema, generation, crash_count, last_active,
				q.rec_reserved_a, q.rec_reserved_b);
		sub_ok  = q.subsystem != '0 && q.subsystem < subsystem_count;
		rewrite = 1'b0;
		o = '0;
		o.record_was_valid = intact;
		o.accepted         = 1'b1;
		o.new_checksum     = q.rec_checksum;
		case (q.command)
		CMD_NOTE_BOOT: begin
			if (!intact)
				{schema, generation, crash_count, last_active} = {schema_id, 32'd1, 16'd0};
			o.previous_active = last_active;
			o.crash_blamed    = q.boot_after_crash && last_active != '0;
			if (o.crash_blamed) begin
				if (crash_count != 8'hFF)
					crash_count = crash_count + 8'd1;
			end else begin
				crash_count = '0;
			end
			last_active  = '0;
			rewrite      = 1'b1;
			o.crash_loop = o.crash_blamed && crash_count >= failure_limit;
		end
		CMD_MARK: begin
			if (!sub_ok) begin
				o.accepted = 1'b0;
			end else begin
				if (!intact)
					{schema, generation, crash_count, last_active} = {schema_id, 32'd1, 16'd0};
				last_active = q.subsystem;
				rewrite     = 1'b1;
			end
		end
		CMD_ACK: begin
			if (!intact || !sub_ok || last_active != q.subsystem || crash_count == '0) begin
				o.accepted = 1'b0;
			end else begin
				crash_count = '0;
				rewrite     = 1'b1;
			end
		end
		CMD_CLEAR: begin
			if (!intact)
				{schema, generation, crash_count, last_active} = {schema_id, 32'd1, 16'd0};
			crash_count = '0;
			last_active = '0;
			rewrite     = 1'b1;
		end
		default: ;
		endcase
		if (rewrite) begin
			generation     = (generation == '1) ? 32'd1 : generation + 32'd1;
			o.new_checksum = record_seal(schema, generation, crash_count, last_active,
				8'd0, 8'd0);
		end
		o.new_schema      = schema;
		o.new_generation  = generation;
		o.new_crash_count = crash_count;
		o.new_last_active = last_active;
		o.record_changed  = rewrite;
		return o;
	endfunction

	task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= 10)
				$display("%0t mismatch on %s: expected %h, got %h", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		if (!arst_n) begin
			schema_id       = 32'd1;
			failure_limit   = 8'd3;
			subsystem_count = 8'd2;
			awaited_outcomes.delete();
			errors = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.addr)
				CFG_SCHEMA_ID:       schema_id       = cfg.data;
				CFG_FAILURE_LIMIT:   failure_limit   = cfg.data[7:0];
				CFG_SUBSYSTEM_COUNT: subsystem_count = cfg.data[7:0];
				default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (awaited_outcomes.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t result with no request outstanding: %h", $time, rsp.data);
				end else begin
					want = awaited_outcomes.pop_front();
					check_field("new_schema", want.new_schema, rsp.data.new_schema);
					check_field("new_generation", want.new_generation, rsp.data.new_generation);
					check_field("new_crash_count", 32'(want.new_crash_count),
						32'(rsp.data.new_crash_count));
					check_field("new_last_active", 32'(want.new_last_active),
						32'(rsp.data.new_last_active));
					check_field("new_checksum", want.new_checksum, rsp.data.new_checksum);
					check_field("record_changed", 32'(want.record_changed),
						32'(rsp.data.record_changed));
					check_field("record_was_valid", 32'(want.record_was_valid),
						32'(rsp.data.record_was_valid));
					check_field("previous_active", 32'(want.previous_active),
						32'(rsp.data.previous_active));
					check_field("crash_blamed", 32'(want.crash_blamed),
						32'(rsp.data.crash_blamed));
					check_field("crash_loop", 32'(want.crash_loop), 32'(rsp.data.crash_loop));
					check_field("accepted", 32'(want.accepted), 32'(rsp.data.accepted));
				end
			end
			if (req.valid && req.ready)
				awaited_outcomes.push_back(guard_outcome(req.data));
		end
		pending = awaited_outcomes.size();
	end

endmodule

@@ tb/tb_crash_loop_boot_record_guard.sv @@
`timescale 1ns / 1ps
// Testbench top for the crash loop boot record guard: clock, reset, request and
// register stimulus, result back-pressure and the verdict.
// Depends on clbrg_pkg, clbrg_if, crash_loop_boot_record_guard and clbrg_outcome_checker.
module tb_crash_loop_boot_record_guard;
	import clbrg_pkg::*;

	logic        clk;
	logic        arst_n;
	int          errors;
	int          pending;
	logic        quiet;        // when high the request side sends back to back
	logic [31:0] set_schema;   // register values as last written, for stimulus only
	logic [7:0]  set_limit;
	logic [7:0]  set_subs;

	clbrg_req_if req_ch();
	clbrg_rsp_if rsp_ch();
	clbrg_cfg_if cfg_ch();

	crash_loop_boot_record_guard dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Watches all three channels beside the block; reports back a count of failures.
	clbrg_outcome_checker chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.cfg     (cfg_ch),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run (long gaps and stalls on every request).
	initial begin
		#2_000_000;
		$display("tb_crash_loop_boot_record_guard: errors");
		$finish;
	end

	// Seal a record from the package's column table; the checker recomputes the
	// CRC bit by bit, so a broken table still shows up as a mismatch.
	function automatic logic [31:0] crc_seal(req_t q);
		logic [95:0] stream;
		logic [31:0] c;
		stream = {q.rec_reserved_b, q.rec_reserved_a, q.rec_last_active, q.rec_crash_count,
			q.rec_generation, q.rec_schema};
		c = CRC_ZERO;
		for (int i = 0; i < CRC_BITS; i++)
			if (stream[i])
				c = c ^ CRC_COL[i];
		return c;
	endfunction

	// Well-formed record under the current schema with zero reserved bytes.
	function automatic req_t boot_record(logic [2:0] command, logic crash, logic [7:0] subsystem,
			logic [31:0] generation, logic [7:0] crash_count, logic [7:0] last_active);
		req_t q;
		q = '0;
		q.command          = command;
		q.boot_after_crash = crash;
		q.subsystem        = subsystem;
		q.rec_schema       = set_schema;
		q.rec_generation   = generation;
		q.rec_crash_count  = crash_count;
		q.rec_last_active  = last_active;
		q.rec_checksum     = crc_seal(q);
		return q;
	endfunction

	// Offer one request from the falling edge and hold it until the block takes it.
	// Gaps are mostly nil or short, now and then long; none while quiet is set.
	task automatic push(req_t q);
		int r;
		int gap;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			gap = 0;
		else if (r < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(6, 20);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= q;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	task automatic write_reg(cfg_addr_t index, logic [31:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr  <= index;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
	endtask

	// Rewrite all three registers; only ever called with nothing in flight.
	task automatic retune(logic [31:0] schema, logic [7:0] limit, logic [7:0] subs);
		write_reg(CFG_SCHEMA_ID, schema);
		write_reg(CFG_FAILURE_LIMIT, {24'd0, limit});
		write_reg(CFG_SUBSYSTEM_COUNT, {24'd0, subs});
		cfg_ch.valid <= 1'b0;
		set_schema = schema;
		set_limit  = limit;
		set_subs   = subs;
	endtask

	// Random requests, then drop valid and wait for every result to come back.
	// Three in four records are well formed so that boots, marks and acknowledges
	// reach their interesting branches; the rest carry one fault or are pure noise.
	task automatic run_batch(int items);
		req_t q;
		int   r;
		int   fault;
		for (int n = 0; n < items; n++) begin
			if (n % 50 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			q = '0;
			r = $urandom_range(0, 99);
			if (r < 30)
				q.command = CMD_NOTE_BOOT;
			else if (r < 50)
				q.command = CMD_MARK;
			else if (r < 70)
				q.command = CMD_ACK;
			else if (r < 82)
				q.command = CMD_CLEAR;
			else if (r < 94)
				q.command = CMD_CHECK;
			else
				q.command = CMD_CHECK + 3'($urandom_range(1, 3));  // unused codes
			q.boot_after_crash = 1'($urandom_range(0, 1));
			q.rec_schema = set_schema;
			r = $urandom_range(0, 99);
			if (r < 8)
				q.rec_generation = '1;
			else if (r < 12)
				q.rec_generation = 32'hFFFF_FFFE;
			else if (r < 18)
				q.rec_generation = 32'd1;
			else
				q.rec_generation = $urandom;
			if (q.rec_generation == '0)
				q.rec_generation = 32'd1;
			// bias the count towards saturation and the loop threshold
			case ($urandom_range(0, 5))
			0: q.rec_crash_count = '0;
			1: q.rec_crash_count = 8'hFF;
			2: q.rec_crash_count = 8'hFE;
			3: q.rec_crash_count = set_limit - 8'd1;
			4: q.rec_crash_count = set_limit;
			default: q.rec_crash_count = 8'($urandom);
			endcase
			if (set_subs != '0)
				q.rec_last_active = 8'($urandom_range(0, int'(set_subs) - 1));
			r = $urandom_range(0, 99);
			if ((q.command == CMD_MARK || q.command == CMD_ACK) && r < 60 && set_subs > 8'd1) begin
				if (q.rec_last_active != '0 && r < 40)
					q.subsystem = q.rec_last_active;
				else
					q.subsystem = 8'($urandom_range(1, int'(set_subs) - 1));
			end else begin
				case ($urandom_range(0, 3))
				0: q.subsystem = '0;
				1: q.subsystem = set_subs;
				2: q.subsystem = 8'hFF;
				default: q.subsystem = 8'($urandom);
				endcase
			end
			fault = ($urandom_range(0, 99) < 25) ? $urandom_range(0, 6) : -1;
			case (fault)
			0: q.rec_schema = q.rec_schema ^ (32'd1 << $urandom_range(0, 31));
			1: q.rec_generation = '0;
			2: q.rec_last_active = 8'($urandom_range(int'(set_subs), 255));
			3: q.rec_reserved_a = 8'($urandom_range(1, 255));
			4: q.rec_reserved_b = 8'($urandom_range(1, 255));
			6: begin
				q.subsystem       = 8'($urandom);
				q.rec_schema      = $urandom;
				q.rec_generation  = $urandom;
				q.rec_crash_count = 8'($urandom);
				q.rec_last_active = 8'($urandom);
				q.rec_reserved_a  = 8'($urandom);
				q.rec_reserved_b  = 8'($urandom);
			end
			default: ;
			endcase
			if (fault == 6)
				q.rec_checksum = $urandom;
			else
				q.rec_checksum = crc_seal(q);
			if (fault == 5)
				q.rec_checksum = q.rec_checksum ^ (32'd1 << $urandom_range(0, 31));
			push(q);
		end
		req_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// Result side: ready by default, short stalls fairly often, the odd long one,
	// and calm stretches with no stall at all.
	initial begin : result_sink
		int stall;
		int calm;
		int r;
		rsp_ch.ready = 1'b0;
		stall = 0;
		calm  = 0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				stall--;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (calm > 0) begin
					calm--;
				end else begin
					r = $urandom_range(0, 99);
					if (r < 4)
						calm = $urandom_range(30, 120);
					else if (r < 20)
						stall = $urandom_range(1, 2);
					else if (r < 23)
						stall = $urandom_range(8, 30);
				end
			end
		end
	end

	initial begin : stimulus
		req_t q;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.addr  = '0;
		cfg_ch.data  = '0;
		quiet        = 1'b0;
		set_schema   = 32'd1;
		set_limit    = 8'd3;
		set_subs     = 8'd2;
		arst_n       = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed requests under the reset registers: schema 1, limit 3, two codes.
		push(boot_record(CMD_NOTE_BOOT, 1'b1, 8'd0, 32'd7, 8'd2, 8'd1));  // crash reaches limit
		push(boot_record(CMD_NOTE_BOOT, 1'b1, 8'd0, 32'd9, 8'hFF, 8'd1)); // count saturates
		push(boot_record(CMD_NOTE_BOOT, 1'b0, 8'd0, 32'd3, 8'd5, 8'd1));  // clean boot
		push(boot_record(CMD_NOTE_BOOT, 1'b1, 8'd0, 32'd3, 8'd5, 8'd0));  // crash, nobody active
		push(boot_record(CMD_NOTE_BOOT, 1'b0, 8'd0, '1, 8'd0, 8'd0));     // generation wraps
		q = boot_record(CMD_NOTE_BOOT, 1'b1, 8'd0, 32'd4, 8'd2, 8'd1);
		q.rec_reserved_a = 8'h80;
		q.rec_checksum   = crc_seal(q);
		push(q);                                                           // reinitialise
		q = boot_record(CMD_NOTE_BOOT, 1'b1, 8'd0, 32'd4, 8'd2, 8'd2);    // last out of range
		push(q);
		push(boot_record(CMD_MARK, 1'b0, 8'd1, 32'd10, 8'd0, 8'd0));
		push(boot_record(CMD_MARK, 1'b0, 8'd0, 32'd10, 8'd0, 8'd0));      // code none
		push(boot_record(CMD_MARK, 1'b0, 8'd2, 32'd10, 8'd0, 8'd0));      // code at the count
		q = boot_record(CMD_MARK, 1'b0, 8'd1, 32'd10, 8'd0, 8'd0);
		q.rec_checksum = q.rec_checksum ^ 32'd1;
		push(q);                                                           // bad seal, reinit
		push(boot_record(CMD_ACK, 1'b0, 8'd1, 32'd11, 8'd4, 8'd1));       // good acknowledge
		push(boot_record(CMD_ACK, 1'b0, 8'd1, 32'd11, 8'd0, 8'd1));       // nothing to clear
		push(boot_record(CMD_ACK, 1'b0, 8'd1, 32'd11, 8'd4, 8'd0));       // not the active one
		push(boot_record(CMD_ACK, 1'b0, 8'hFF, 32'd11, 8'd4, 8'd1));      // code out of range
		q = boot_record(CMD_ACK, 1'b0, 8'd1, 32'd11, 8'd4, 8'd1);
		q.rec_reserved_b = 8'h01;
		q.rec_checksum   = crc_seal(q);
		push(q);                                                           // invalid record
		push(boot_record(CMD_CLEAR, 1'b1, 8'd0, 32'd20, 8'd9, 8'd1));
		q = boot_record(CMD_CLEAR, 1'b1, 8'd0, 32'd20, 8'd9, 8'd1);
		q.rec_schema   = ~q.rec_schema;
		q.rec_checksum = crc_seal(q);
		push(q);                                                           // foreign schema
		push(boot_record(CMD_CHECK, 1'b1, 8'd0, 32'd5, 8'd1, 8'd1));
		push(boot_record(CMD_CHECK, 1'b0, 8'd0, 32'd0, 8'd0, 8'd0));      // zero generation
		for (int k = 1; k <= 3; k++)
			push(boot_record(CMD_CHECK + 3'(k), 1'b1, 8'd1, 32'd6, 8'd2, 8'd1));  // unused codes
		q = '1;
		q.command = CMD_NOTE_BOOT;
		push(q);
		q = '0;
		q.command = CMD_CLEAR;
		push(q);
		run_batch(150);

		// Walk through the register extremes and a few random settings, including
		// the small limits and counts that reject everything or loop at once.
		retune(32'hFFFF_FFFF, 8'hFF, 8'hFF);
		run_batch(175);
		retune(32'd0, 8'd0, 8'd0);
		run_batch(175);
		retune($urandom, 8'd1, 8'd1);
		run_batch(175);
		retune($urandom, 8'($urandom_range(2, 255)), 8'($urandom_range(2, 255)));
		run_batch(175);
		retune($urandom, 8'hFF, 8'd3);
		run_batch(175);
		retune($urandom, 8'($urandom_range(2, 6)), 8'($urandom_range(2, 16)));
		run_batch(175);
		retune(32'd1, 8'd2, 8'd2);
		run_batch(175);

		// Let the pipeline run dry before the verdict.
		repeat (8) @(negedge clk);
		if (errors == 0) begin
			$display("tb_crash_loop_boot_record_guard: clean");
		end else begin
			$display("tb_crash_loop_boot_record_guard: errors");
		end
		$finish;
	end

endmodule
